/* rtl/okc_pkg.sv */
// ----------------------------------------------------------------------------
// okc_pkg
// Types, codes and the CRC8 byte step shared by the ROM key checker files.
// ----------------------------------------------------------------------------
`default_nettype none

package okc_pkg;

  localparam int KEY_COUNT_DEFAULT = 2;
  localparam int KEY_BYTES_DEFAULT = 6;

  // Keys that have a configuration register.
  localparam int KEY_REGS  = 2;
  localparam int KEY_W     = 48;
  localparam int CFG_IDX_W = 2;

  // Position of the CRC byte within the ROM read.
  localparam logic [2:0] CRC_BYTE_IDX = 3'd7;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STORED_KEY_0 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STORED_KEY_1 = 2'd2;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_DEVICE    = 3'd1,
    ST_CRC_ERROR    = 3'd2,
    ST_KEY_MISMATCH = 3'd3,
    ST_DISABLED     = 3'd4
  } status_t;

  typedef enum logic {
    CMD_PRESENCE = 1'b0,
    CMD_ROM_BYTE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       present;
    logic [7:0] rom_byte;
  } item_t;

  typedef struct packed {
    status_t status;
    logic    locked;
  } result_t;

  // Dallas CRC8, reflected, one byte, LSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] crc;
    logic       mix;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      mix = crc[0] ^ b[k];
      crc = {1'b0, crc[7:1]};
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

/* rtl/onewire_rom_key_checker.sv */
// ----------------------------------------------------------------------------
// onewire_rom_key_checker
// Immobilizer key check over a 1-Wire ROM read: CRC8 plus stored key match.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): one word per cycle while
//   item_stall is low. A presence word (cmd 0) opens a check; the following
//   eight ROM byte words are the family code, six serial bytes and the CRC.
//   ROM bytes that come outside a check are dropped without a result.
//   result channel (result_valid / result_stall / result): one word for a
//   presence word that ends the check at once (disabled, no device) and one
//   word on the CRC byte (ok, crc error, key mismatch). locked is the sticky
//   lock flag after that check.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//   writes, always ready; index 0 enable, 1 and 2 the stored keys.
// Throughput: one item word per cycle while item_stall is low. The result
//   word is computed combinationally from the accepted word and the check
//   state and registered in the result register, or in the skid while stalled.
// Stall: a two-word output buffer (result register plus skid). item_stall
//   is high only while the skid word is held, so words without a result keep
//   flowing while the receiver stalls.
// Reset: rst (synchronous) clears the check, the lock flag, the keys and the
//   enable; the lock flag is cleared by nothing else.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_rom_key_checker #(
  parameter int KEY_COUNT = okc_pkg::KEY_COUNT_DEFAULT,
  parameter int KEY_BYTES = okc_pkg::KEY_BYTES_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // item channel
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire okc_pkg::item_t                item,
  // result channel
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output okc_pkg::result_t                   result,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [okc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [okc_pkg::KEY_W-1:0]     cfg_data
);

  // Only keys with a register can take part.
  localparam int ACTIVE_KEYS = (KEY_COUNT < okc_pkg::KEY_REGS) ? KEY_COUNT : okc_pkg::KEY_REGS;
  localparam logic [2:0] LAST_KEY_IDX = 3'(KEY_BYTES);

  // configuration
  logic                     check_enable;
  logic [okc_pkg::KEY_W-1:0] stored_key [okc_pkg::KEY_REGS];

  // check state
  logic [2:0]             byte_index, byte_index_next;
  logic                   reading, reading_next;
  logic [7:0]             running_crc, running_crc_next;
  logic [ACTIVE_KEYS-1:0] key_matches, key_matches_next;
  logic                   lock_flag, lock_flag_next;

  // result computed for the accepted word
  logic             res_push;
  okc_pkg::result_t res_word;

  // output buffer
  logic             skid_valid;
  okc_pkg::result_t skid;

  logic item_acc, result_take;
  logic [2:0] key_sel;
  logic [okc_pkg::KEY_W-1:0] key_sh;

  assign cfg_ready   = 1'b1;
  assign item_stall  = skid_valid;
  assign item_acc    = item_valid & ~item_stall;
  assign result_take = result_valid & ~result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable <= 1'b0;
      for (int k = 0; k < okc_pkg::KEY_REGS; k++) begin
        stored_key[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        okc_pkg::REG_CHECK_ENABLE: check_enable  <= cfg_data[0];
        okc_pkg::REG_STORED_KEY_0: stored_key[0] <= cfg_data;
        okc_pkg::REG_STORED_KEY_1: stored_key[1] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Key byte j = byte_index - 1 lines up with ROM byte byte_index.
  assign key_sel = byte_index - 3'd1;

  always_comb begin
    byte_index_next  = byte_index;
    reading_next     = reading;
    running_crc_next = running_crc;
    key_matches_next = key_matches;
    lock_flag_next   = lock_flag;
    res_push         = 1'b0;
    res_word.status  = okc_pkg::ST_OK;
    res_word.locked  = lock_flag;
    key_sh           = '0;

    if (item_acc) begin
      if (item.cmd == okc_pkg::CMD_PRESENCE) begin
        reading_next    = 1'b0;
        byte_index_next = '0;
        if (!check_enable) begin
          res_push        = 1'b1;
          res_word.status = okc_pkg::ST_DISABLED;
        end else if (!item.present) begin
          lock_flag_next  = 1'b1;
          res_push        = 1'b1;
          res_word.status = okc_pkg::ST_NO_DEVICE;
          res_word.locked = 1'b1;
        end else begin
          reading_next     = 1'b1;
          running_crc_next = '0;
          key_matches_next = '1;
        end
      end else if (reading) begin
        if (byte_index != okc_pkg::CRC_BYTE_IDX) begin
          running_crc_next = okc_pkg::crc8_step(running_crc, item.rom_byte);
          if (byte_index != 3'd0 && byte_index <= LAST_KEY_IDX) begin
            for (int k = 0; k < ACTIVE_KEYS; k++) begin
              key_sh = stored_key[k] >> {key_sel, 3'b000};
              if (key_sh[7:0] != item.rom_byte) begin
                key_matches_next[k] = 1'b0;
              end
            end
          end
          byte_index_next = byte_index + 3'd1;
        end else begin
          // CRC byte: CRC error wins over a key mismatch
          res_push = 1'b1;
          if (running_crc != item.rom_byte) begin
            res_word.status = okc_pkg::ST_CRC_ERROR;
          end else if (key_matches == '0) begin
            res_word.status = okc_pkg::ST_KEY_MISMATCH;
          end else begin
            res_word.status = okc_pkg::ST_OK;
          end
          if (res_word.status != okc_pkg::ST_OK) begin
            lock_flag_next  = 1'b1;
            res_word.locked = 1'b1;
          end
          reading_next    = 1'b0;
          byte_index_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      reading     <= 1'b0;
      running_crc <= '0;
      key_matches <= '1;
      lock_flag   <= 1'b0;
    end else begin
      byte_index  <= byte_index_next;
      reading     <= reading_next;
      running_crc <= running_crc_next;
      key_matches <= key_matches_next;
      lock_flag   <= lock_flag_next;
    end
  end

  // Output buffer. A push never meets a full skid: item_stall blocks it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_take) begin
      if (skid_valid) begin
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= res_push;
      end
    end else if (!result_valid) begin
      result_valid <= res_push;
    end else if (res_push) begin
      skid_valid   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result_take) begin
      result <= skid_valid ? skid : res_word;
    end else if (!result_valid) begin
      result <= res_word;
    end else if (res_push) begin
      skid <= res_word;
    end
  end

endmodule

`default_nettype wire

/* rtl/okc_checker.sv */
// ----------------------------------------------------------------------------
// okc_checker
// Port-level checks for the ROM key checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module okc_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          item_valid,
  input wire logic                          item_stall,
  input wire okc_pkg::item_t                item,
  input wire logic                          result_valid,
  input wire logic                          result_stall,
  input wire okc_pkg::result_t              result,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready,
  input wire logic [okc_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [okc_pkg::KEY_W-1:0]     cfg_data
);

  // set once a delivered word shows the lock
  logic seen_lock;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_lock <= 1'b0;
    end else if (result_valid && !result_stall && result.locked) begin
      seen_lock <= 1'b1;
    end
  end

  // input only backs up behind a held result word
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("item_stall without a pending result word");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    result_valid && seen_lock |-> result.locked)
    else $error("lock flag dropped after being reported");

  a_fail_locks: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == okc_pkg::ST_NO_DEVICE ||
                     result.status == okc_pkg::ST_CRC_ERROR ||
                     result.status == okc_pkg::ST_KEY_MISMATCH) |-> result.locked)
    else $error("failed check reported unlocked");

endmodule

bind onewire_rom_key_checker okc_checker u_okc_checker (.*);

`default_nettype wire
